[src/gn1d_pkg.sv]
// ----------------------------------------------------------------------------
// gn1d_pkg
// Shared constants and types for the 1-D gradient noise block.
// ----------------------------------------------------------------------------
package gn1d_pkg;

    // Gradient table; depth is a power of two so the index wrap is a mask
    localparam int TABLE_ADDR_BITS = 11;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

    localparam int FRACTION_BITS = 16;
    localparam int GRADIENT_BITS = 16;

    // Field widths
    localparam int POSITION_W = 27;
    localparam int INDEX_W    = 11;
    localparam int GRADIENT_W = 16;
    localparam int NOISE_W    = 17;
    localparam int OUT_FRAC   = 15;
    localparam int NOISE_MAX  = 32768;

    // Fixed-point one and derived widths
    localparam int ONE = 1 << FRACTION_BITS;
    localparam int T_W = FRACTION_BITS + 1;
    localparam int A_W = FRACTION_BITS + 5;

    // Pipeline depth, output register included
    localparam int NSTAGE = 6;

    typedef logic [T_W-1:0] fade_t;

    typedef struct packed {
        logic [NSTAGE:1] en;
    } stage_ctl_t;

endpackage

[src/gn1d_cmd_if.sv]
// ----------------------------------------------------------------------------
// gn1d_cmd_if
// Command channel: evaluate or table load, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gn1d_cmd_if;

    logic                                       valid;
    logic                                       ready;
    logic                                       action;
    logic        [gn1d_pkg::POSITION_W-1:0]     position;
    logic        [gn1d_pkg::INDEX_W-1:0]        table_index;
    logic signed [gn1d_pkg::GRADIENT_W-1:0]     gradient;

    modport source (
        output valid,
        output action,
        output position,
        output table_index,
        output gradient,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  position,
        input  table_index,
        input  gradient,
        output ready
    );

endinterface

[src/gn1d_res_if.sv]
// ----------------------------------------------------------------------------
// gn1d_res_if
// Result channel: noise value or load acknowledge, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gn1d_res_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [gn1d_pkg::NOISE_W-1:0]    noise_value;
    logic                                   was_load;

    modport source (
        output valid,
        output noise_value,
        output was_load,
        input  ready
    );

    modport sink (
        input  valid,
        input  noise_value,
        input  was_load,
        output ready
    );

endinterface

[src/gn1d_ram.sv]
// ----------------------------------------------------------------------------
// gn1d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gn1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/gn1d_fade.sv]
// ----------------------------------------------------------------------------
// gn1d_fade
// Pipelined quintic fade t^3 * (t*(6t-15) + 10), three register stages.
// ----------------------------------------------------------------------------
module gn1d_fade (
    input  logic                   clk,
    input  gn1d_pkg::stage_ctl_t   ctl,
    input  gn1d_pkg::fade_t        t,
    output gn1d_pkg::fade_t        f
);

    localparam int F   = gn1d_pkg::FRACTION_BITS;
    localparam int TW  = gn1d_pkg::T_W;
    localparam int AW  = gn1d_pkg::A_W;
    localparam int TTW = 2 * TW;
    localparam int ATW = AW + TW + 1;
    localparam int FPW = TW + 1 + AW;

    localparam logic signed [AW-1:0]  A_OFS   = AW'(15 * gn1d_pkg::ONE);
    localparam logic signed [AW-1:0]  C_OFS   = AW'(10 * gn1d_pkg::ONE);
    localparam logic        [TTW-1:0] HALF_U  = TTW'(1) << (F - 1);
    localparam logic signed [ATW-1:0] HALF_AT = ATW'(1) << (F - 1);
    localparam logic signed [FPW-1:0] HALF_FP = FPW'(1) << (F - 1);

    // first stage: t*t and (6t-15)*t
    logic signed [TW:0]      ts;
    logic        [TTW-1:0]   tt_c;
    logic signed [AW-1:0]    a_c;
    logic signed [ATW-1:0]   at_c;

    logic        [TTW-1:0]   tt_reg;
    logic signed [ATW-1:0]   at_reg;
    logic        [TW-1:0]    t_reg;

    // second stage: t2*t and c
    logic        [TW-1:0]    t2_c;
    logic        [TTW-1:0]   p3_c;
    logic signed [AW-1:0]    b_c;
    logic signed [AW-1:0]    c_c;

    logic        [TTW-1:0]   p3_reg;
    logic signed [AW-1:0]    c_reg;

    // third stage: t3*c
    logic        [TW-1:0]    t3_c;
    logic signed [FPW-1:0]   fp_c;

    logic signed [FPW-1:0]   fp_reg;
    logic signed [FPW-1:0]   fr_c;

    assign ts   = $signed({1'b0, t});
    assign tt_c = TTW'(t) * TTW'(t);
    assign a_c  = $signed(AW'(t) * AW'(6)) - A_OFS;
    assign at_c = ATW'(a_c) * ATW'(ts);

    assign t2_c = TW'((tt_reg + HALF_U) >> F);
    assign p3_c = TTW'(t2_c) * TTW'(t_reg);
    assign b_c  = AW'((at_reg + HALF_AT) >>> F);
    assign c_c  = b_c + C_OFS;

    assign t3_c = TW'((p3_reg + HALF_U) >> F);
    assign fp_c = FPW'($signed({1'b0, t3_c})) * FPW'(c_reg);

    assign fr_c = (fp_reg + HALF_FP) >>> F;

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            tt_reg <= tt_c;
            at_reg <= at_c;
            t_reg  <= t;
        end
        if (ctl.en[3])
        begin
            p3_reg <= p3_c;
            c_reg  <= c_c;
        end
        if (ctl.en[4])
        begin
            fp_reg <= fp_c;
        end
    end

    // clamp to [0, one]
    always_comb
    begin
        if (fr_c < 0)
        begin
            f = '0;
        end
        else if (fr_c > FPW'(gn1d_pkg::ONE))
        begin
            f = TW'(gn1d_pkg::ONE);
        end
        else
        begin
            f = TW'(fr_c);
        end
    end

endmodule

[src/gradient_noise_1d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_1d
// One-dimensional gradient noise over a software-filled gradient table.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+----------------------
//  cmd      | in  | action, position, table_index, gradient   | cmd.valid & cmd.ready
//  result   | out | noise_value, was_load                     | result.valid & result.ready
//
//  One transfer per cycle in both directions while results are taken; a result
//  leaves after its command passes the RAM read, four arithmetic stages and
//  the output register. The rate is set by the two table copies, which give
//  both gradient reads in the same cycle, and by one multiplier row per stage.
//  Each stage holds only when it is full and the one after it holds, so bubbles
//  close up and commands keep flowing while a result waits, until the stages fill.
//  Reset clears the stage valid flags only; the table has no reset and no
//  clearing pass, an entry must be loaded before it is evaluated.
//
module gradient_noise_1d (
    input  logic           clk,
    input  logic           rst_n,
    gn1d_cmd_if.sink       cmd,
    gn1d_res_if.source     result
);

    localparam int F   = gn1d_pkg::FRACTION_BITS;
    localparam int G   = gn1d_pkg::GRADIENT_BITS;
    localparam int AB  = gn1d_pkg::TABLE_ADDR_BITS;
    localparam int NS  = gn1d_pkg::NSTAGE;
    localparam int TW  = gn1d_pkg::T_W;
    localparam int NW  = gn1d_pkg::NOISE_W;
    localparam int VW  = F + 2;          // rounded k*g, Q.F signed
    localparam int PW  = F + G + 2;      // raw k*g product
    localparam int MW  = VW + TW + 1;    // v * fade
    localparam int SW  = MW + 1;         // sum of both terms
    localparam int OSH = 2 * F - gn1d_pkg::OUT_FRAC;

    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (G - 2);
    localparam logic signed [SW-1:0] HALF_S = SW'(1) << (OSH - 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(gn1d_pkg::NOISE_MAX);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(gn1d_pkg::NOISE_MAX);

    // ---------------------------------------------------------------- control
    logic [NS:1]           valid_reg;
    logic [NS:1]           rdy;
    gn1d_pkg::stage_ctl_t  ctl;
    logic                  cmd_xfer;

    always_comb
    begin
        rdy[NS] = !valid_reg[NS] || result.ready;
        for (int s = NS - 1; s >= 1; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s + 1];
        end
    end

    assign ctl.en    = rdy;
    assign cmd.ready = rdy[1];
    assign cmd_xfer  = cmd.valid && rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= cmd.valid;
            end
            for (int s = 2; s <= NS; s++)
            begin
                if (rdy[s])
                begin
                    valid_reg[s] <= valid_reg[s - 1];
                end
            end
        end
    end

    // ---------------------------------------------------------- gradient table
    // Two identical copies: both take every load, each serves one neighbour.
    logic [AB-1:0] idx0;
    logic [AB-1:0] idx1;
    logic [G-1:0]  g0_raw;
    logic [G-1:0]  g1_raw;
    logic          tbl_we;
    logic          tbl_re;

    assign idx0   = cmd.position[F+AB-1:F];
    assign idx1   = idx0 + AB'(1);       // wraps at the table size
    assign tbl_we = cmd_xfer && cmd.action;
    assign tbl_re = cmd_xfer && !cmd.action;

    gn1d_ram #(
        .WIDTH (G),
        .DEPTH (gn1d_pkg::TABLE_SIZE)
    ) u_tbl0 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (cmd.table_index[AB-1:0]),
        .wdata (cmd.gradient[G-1:0]),
        .re    (tbl_re),
        .raddr (idx0),
        .rdata (g0_raw)
    );

    gn1d_ram #(
        .WIDTH (G),
        .DEPTH (gn1d_pkg::TABLE_SIZE)
    ) u_tbl1 (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (cmd.table_index[AB-1:0]),
        .wdata (cmd.gradient[G-1:0]),
        .re    (tbl_re),
        .raddr (idx1),
        .rdata (g1_raw)
    );

    // ------------------------------------------------------------- stage 1
    // Gradients arrive from the RAMs; form k*g0, (k-1)*g1 and both fade inputs.
    logic                  load_s1_reg;
    logic [F-1:0]          k_s1_reg;

    gn1d_pkg::fade_t       t_lo;          // 1 - k
    gn1d_pkg::fade_t       t_hi;          // k
    gn1d_pkg::fade_t       f_lo;
    gn1d_pkg::fade_t       f_hi;
    logic signed [F+1:0]   km_c;
    logic signed [PW-1:0]  p1_c;
    logic signed [PW-1:0]  p2_c;

    assign t_lo = TW'(gn1d_pkg::ONE) - {1'b0, k_s1_reg};
    assign t_hi = {1'b0, k_s1_reg};
    assign km_c = $signed({2'b00, k_s1_reg}) - (F + 2)'(gn1d_pkg::ONE);
    assign p1_c = PW'($signed({1'b0, k_s1_reg})) * PW'($signed(g0_raw));
    assign p2_c = PW'(km_c) * PW'($signed(g1_raw));

    gn1d_fade u_fade_lo (
        .clk (clk),
        .ctl (ctl),
        .t   (t_lo),
        .f   (f_lo)
    );

    gn1d_fade u_fade_hi (
        .clk (clk),
        .ctl (ctl),
        .t   (t_hi),
        .f   (f_hi)
    );

    // ------------------------------------------------------------- stage 2..5
    logic                  load_s2_reg;
    logic signed [PW-1:0]  p1_s2_reg;
    logic signed [PW-1:0]  p2_s2_reg;
    logic signed [VW-1:0]  v1_c;
    logic signed [VW-1:0]  v2_c;

    logic                  load_s3_reg;
    logic signed [VW-1:0]  v1_s3_reg;
    logic signed [VW-1:0]  v2_s3_reg;

    logic                  load_s4_reg;
    logic signed [VW-1:0]  v1_s4_reg;
    logic signed [VW-1:0]  v2_s4_reg;
    logic signed [MW-1:0]  m1_c;
    logic signed [MW-1:0]  m2_c;

    logic                  load_s5_reg;
    logic signed [MW-1:0]  m1_s5_reg;
    logic signed [MW-1:0]  m2_s5_reg;
    logic signed [SW-1:0]  sum_c;
    logic signed [SW-1:0]  rnd_c;
    logic signed [NW-1:0]  noise_next;

    logic signed [NW-1:0]  noise_reg;
    logic                  was_load_reg;

    // round half up back to Q.F
    assign v1_c = VW'((p1_s2_reg + HALF_P) >>> (G - 1));
    assign v2_c = VW'((p2_s2_reg + HALF_P) >>> (G - 1));

    // blend as v1*fade(1-k) + v2*fade(k)
    assign m1_c = MW'(v1_s4_reg) * MW'($signed({1'b0, f_lo}));
    assign m2_c = MW'(v2_s4_reg) * MW'($signed({1'b0, f_hi}));

    assign sum_c = SW'(m1_s5_reg) + SW'(m2_s5_reg);
    assign rnd_c = (sum_c + HALF_S) >>> OSH;

    always_comb
    begin
        if (load_s5_reg)
        begin
            noise_next = '0;
        end
        else if (rnd_c > SAT_HI)
        begin
            noise_next = NW'(SAT_HI);
        end
        else if (rnd_c < SAT_LO)
        begin
            noise_next = NW'(SAT_LO);
        end
        else
        begin
            noise_next = NW'(rnd_c);
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            load_s1_reg <= cmd.action;
            k_s1_reg    <= cmd.position[F-1:0];
        end
        if (ctl.en[2])
        begin
            load_s2_reg <= load_s1_reg;
            p1_s2_reg   <= p1_c;
            p2_s2_reg   <= p2_c;
        end
        if (ctl.en[3])
        begin
            load_s3_reg <= load_s2_reg;
            v1_s3_reg   <= v1_c;
            v2_s3_reg   <= v2_c;
        end
        if (ctl.en[4])
        begin
            load_s4_reg <= load_s3_reg;
            v1_s4_reg   <= v1_s3_reg;
            v2_s4_reg   <= v2_s3_reg;
        end
        if (ctl.en[5])
        begin
            load_s5_reg <= load_s4_reg;
            m1_s5_reg   <= m1_c;
            m2_s5_reg   <= m2_c;
        end
        if (ctl.en[6])
        begin
            noise_reg    <= noise_next;
            was_load_reg <= load_s5_reg;
        end
    end

    // ---------------------------------------------------------------- output
    assign result.valid       = valid_reg[NS];
    assign result.noise_value = noise_reg;
    assign result.was_load    = was_load_reg;

endmodule

[src/gn1d_checker.sv]
// ----------------------------------------------------------------------------
// gn1d_checker
// Port-level checks on the gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn1d_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_ready,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic signed [gn1d_pkg::NOISE_W-1:0] noise_value,
    input logic                               was_load
);

    // held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(noise_value) && $stable(was_load))
        else $error("result payload changed while stalled");

    // a load acknowledge carries zero noise
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && was_load |-> noise_value == 0)
        else $error("load acknowledge with non-zero noise");

    // saturation keeps the value within one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !was_load |->
            (noise_value >= -32768) && (noise_value <= 32768))
        else $error("noise value outside saturation range");

    // with an empty output register the pipe always takes a command
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> cmd_ready)
        else $error("command stalled while output is empty");

endmodule

bind gradient_noise_1d gn1d_checker u_gn1d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ready    (cmd.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .noise_value  (result.noise_value),
    .was_load     (result.was_load)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gradient_noise_1d. Gradient loads and noise
// evaluations go in on the command channel. A scoreboard keeps its own copy of
// the gradient table and works out each noise value in fixed point. Results are
// compared in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gn1d_pkg::*;

    // Command opcode on the action bit
    typedef enum logic
    {
        ACT_EVALUATE = 1'b0,
        ACT_LOAD     = 1'b1
    } action_e;

    typedef struct
    {
        logic signed [NOISE_W-1:0] noise_value;
        logic                      was_load;
    } noise_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow gradient table, noise predictor, queue of results due
    // ------------------------------------------------------------------------
    class gradient_noise_scoreboard;

        logic signed [GRADIENT_W-1:0] grad_table [TABLE_SIZE];
        bit                           written    [TABLE_SIZE];
        noise_result_t                expected_noise [$];
        int                           errors;
        int                           loads_seen;
        int                           evals_seen;
        int                           results_checked;

        // add half an LSB, then floor (arithmetic shift floors)
        function longint round_off(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        // 6t^5 - 15t^4 + 10t^3 in Q.16, clamped to [0, 1]
        function longint fade_q16(longint t);
            longint t2, t3, a, b, c, f;
            t2 = round_off(t * t, FRACTION_BITS);
            t3 = round_off(t2 * t, FRACTION_BITS);
            a  = 6 * t - 15 * longint'(ONE);
            b  = round_off(a * t, FRACTION_BITS);
            c  = b + 10 * longint'(ONE);
            f  = round_off(t3 * c, FRACTION_BITS);
            if (f < 0)
                f = 0;
            if (f > ONE)
                f = ONE;
            return f;
        endfunction

        function void note_command(action_e act, logic [POSITION_W-1:0] pos,
                                   logic [INDEX_W-1:0] idx,
                                   logic signed [GRADIENT_W-1:0] grad);
            noise_result_t          res;
            logic [INDEX_W-1:0]     i0, i1;
            longint                 k, g0, g1, v1, v2, sum, r;
            if (act == ACT_LOAD)
            begin
                grad_table[idx] = grad;
                written[idx]    = 1'b1;
                res.noise_value = '0;
                res.was_load    = 1'b1;
                loads_seen++;
            end
            else
            begin
                i0  = pos[POSITION_W-1:FRACTION_BITS];
                i1  = i0 + 1'b1;            // wraps at the table end
                k   = longint'(pos[FRACTION_BITS-1:0]);
                g0  = longint'(grad_table[i0]);
                g1  = longint'(grad_table[i1]);
                v1  = round_off(k * g0, GRADIENT_BITS - 1);
                v2  = round_off((k - ONE) * g1, GRADIENT_BITS - 1);
                sum = v1 * fade_q16(ONE - k) + v2 * fade_q16(k);
                r   = round_off(sum, 2 * FRACTION_BITS - OUT_FRAC);
                if (r > NOISE_MAX)
                    r = NOISE_MAX;
                if (r < -NOISE_MAX)
                    r = -NOISE_MAX;
                res.noise_value = r[NOISE_W-1:0];
                res.was_load    = 1'b0;
                evals_seen++;
            end
            expected_noise.push_back(res);
        endfunction

        function void check_result(logic signed [NOISE_W-1:0] noise, logic ld);
            noise_result_t want;
            if (expected_noise.size() == 0)
            begin
                $error("unexpected result: noise_value %0d, was_load %0b", noise, ld);
                errors++;
                return;
            end
            want = expected_noise.pop_front();
            results_checked++;
            if (ld !== want.was_load)
            begin
                $error("was_load: expected %0b, got %0b", want.was_load, ld);
                errors++;
            end
            if (noise !== want.noise_value)
            begin
                $error("noise_value: expected %0d, got %0d", want.noise_value, noise);
                errors++;
            end
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, block under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    bit   quiet;        // set during phases that run with no idling at all

    gradient_noise_scoreboard sb = new;

    gn1d_cmd_if cmd_ch ();
    gn1d_res_if res_ch ();

    gradient_noise_1d uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [GRADIENT_W-1:0] random_gradient();
        case ($urandom_range(0, 15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return GRADIENT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRACTION_BITS-1:0] random_fraction();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            default: return FRACTION_BITS'($urandom);
        endcase
    endfunction

    // First index at or after start whose entry and successor are both loaded,
    // so an evaluation never touches an unloaded entry
    function automatic logic [INDEX_W-1:0] find_pair(logic [INDEX_W-1:0] start);
        logic [INDEX_W-1:0] i, nxt;
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            i   = start + INDEX_W'(n);
            nxt = i + 1'b1;
            if (sb.written[i] && sb.written[nxt])
                return i;
        end
        return '0;
    endfunction

    function automatic logic [INDEX_W-1:0] find_written(logic [INDEX_W-1:0] start);
        logic [INDEX_W-1:0] i;
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            i = start + INDEX_W'(n);
            if (sb.written[i])
                return i;
        end
        return '0;
    endfunction

    // One command transfer. valid is only dropped when a gap is due, so
    // back-to-back commands keep it high across the edge.
    task automatic send_command(action_e act, logic [POSITION_W-1:0] pos,
                                logic [INDEX_W-1:0] idx,
                                logic signed [GRADIENT_W-1:0] grad);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.position    <= pos;
        cmd_ch.table_index <= idx;
        cmd_ch.gradient    <= grad;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(act, pos, idx, grad);
    endtask

    // Unused fields carry random junk; the block must ignore them
    task automatic load_gradient(logic [INDEX_W-1:0] idx,
                                 logic signed [GRADIENT_W-1:0] grad);
        send_command(ACT_LOAD, POSITION_W'($urandom), idx, grad);
    endtask

    task automatic evaluate_at(logic [INDEX_W-1:0] i, logic [FRACTION_BITS-1:0] frac);
        send_command(ACT_EVALUATE, {i, frac}, INDEX_W'($urandom), GRADIENT_W'($urandom));
    endtask

    // Random traffic: mostly evaluations over loaded pairs, single loads
    // (anywhere, or next to a loaded entry so new pairs keep appearing) and
    // short load-load-evaluate runs over a fresh pair
    task automatic random_command();
        int                 r, n;
        logic [INDEX_W-1:0] i;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            i = INDEX_W'($urandom);
            load_gradient(i, random_gradient());
            load_gradient(i + 1'b1, random_gradient());
            n = $urandom_range(2, 4);
            repeat (n) evaluate_at(i, random_fraction());
        end
        else if (r < 30)
        begin
            if ($urandom_range(0, 1))
                i = INDEX_W'($urandom);
            else
            begin
                i = find_written(INDEX_W'($urandom));
                i = $urandom_range(0, 1) ? i + 1'b1 : i - 1'b1;
            end
            load_gradient(i, random_gradient());
        end
        else
            evaluate_at(find_pair(INDEX_W'($urandom)), random_fraction());
    endtask

    task automatic run_random(int count);
        int target;
        target = sb.loads_seen + sb.evals_seen + count;
        while (sb.loads_seen + sb.evals_seen < target)
            random_command();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, every transfer goes to the scoreboard
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.noise_value, res_ch.was_load);
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= ACT_EVALUATE;
        cmd_ch.position    <= '0;
        cmd_ch.table_index <= '0;
        cmd_ch.gradient    <= '0;
        res_ch.ready       <= 1'b0;
        quiet               = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: gradient extremes at the table ends and around the
        // index midpoint, so the wrap from the last entry to entry zero is hit
        load_gradient(11'd0,    16'sh7FFF);
        load_gradient(11'd1,    16'sh8000);
        load_gradient(11'd2,    16'sh0000);
        load_gradient(11'd2047, 16'shFFFF);
        load_gradient(11'd1023, 16'sh5555);
        load_gradient(11'd1024, 16'shAAAA);

        // fraction at zero, one LSB, half and all ones
        evaluate_at(11'd0,    16'h0000);
        evaluate_at(11'd0,    16'hFFFF);
        evaluate_at(11'd0,    16'h8000);
        evaluate_at(11'd1,    16'h0001);
        evaluate_at(11'd1,    16'hC000);
        evaluate_at(11'd1023, 16'h4000);
        evaluate_at(11'd2047, 16'h0000);    // index wrap
        evaluate_at(11'd2047, 16'hFFFF);    // largest position
        evaluate_at(11'd2047, 16'h8000);

        // overwrite an entry and read it back through both neighbours
        load_gradient(11'd0, 16'sh8000);
        evaluate_at(11'd0,    16'h7FFF);
        evaluate_at(11'd2047, 16'h8000);

        // Random: idling on both sides, then a burst with none, then idling again
        run_random(700);
        quiet = 1'b1;
        run_random(250);
        quiet = 1'b0;
        run_random(250);

        cmd_ch.valid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (sb.expected_noise.size() != 0)
            @(posedge clk);
        repeat (4 * NSTAGE) @(posedge clk);

        $display("Sent %0d commands: %0d gradient loads, %0d noise evaluations.",
                 sb.loads_seen + sb.evals_seen, sb.loads_seen, sb.evals_seen);
        $display("Checked %0d results under random stalls on both channels.",
                 sb.results_checked);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/gn1d_pkg.sv
src/gn1d_cmd_if.sv
src/gn1d_res_if.sv
src/gn1d_ram.sv
src/gn1d_fade.sv
src/gradient_noise_1d.sv
src/gn1d_checker.sv
test/testbench.sv
